### rtl/timer_divider_search_assert.svh
// assertion macros for the timer divider search block
// included by the top level only, no other dependencies
`ifndef TIMER_DIVIDER_SEARCH_ASSERT_SVH
`define TIMER_DIVIDER_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define TDS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define TDS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define TDS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define TDS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

### rtl/tds_pkg.sv
// shared widths, constants, microcode types and control store
// for the timer divider search block; no dependencies
package tds_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 16;
  localparam int DIV_W         = 16;
  localparam int DIV_STEP_W    = $clog2(DATA_W);
  localparam int CFG_ADDR_W    = 3;
  localparam int COUNTER_LIMIT = 65535;
  localparam int MS_PER_SECOND = 1000;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT        = 4'd0;
  localparam step_t S_SCALE       = 4'd1;
  localparam step_t S_DIV_MS      = 4'd2;
  localparam step_t S_DIV_MS_WAIT = 4'd3;
  localparam step_t S_TICKS       = 4'd4;
  localparam step_t S_ZERO_CHK    = 4'd5;
  localparam step_t S_DIV_D       = 4'd6;
  localparam step_t S_DIV_D_WAIT  = 4'd7;
  localparam step_t S_FIT_CHK     = 4'd8;
  localparam step_t S_NEXT_D      = 4'd9;
  localparam step_t S_FAIL        = 4'd10;
  localparam step_t S_FOUND       = 4'd11;
  localparam step_t S_EMIT        = 4'd12;
  localparam step_t S_CLOSE       = 4'd13;

  localparam logic CFG_IDX_CLOCK_HZ   = 1'b0;
  localparam logic CFG_IDX_MULTIPLIER = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_MUL_SCALE,
    OP_DIV_MS,
    OP_MUL_TICKS,
    OP_SET_D1,
    OP_DIV_D,
    OP_INC_D,
    OP_SET_FAIL,
    OP_SET_FOUND,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_DIV_BUSY,
    C_TICKS_ZERO,
    C_FIT,
    C_D_NOT_LAST,
    C_Q_SMALL,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // control store: jump to target when the condition holds, else next step
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      S_WAIT:        w = '{op: OP_LOAD_IN,   cond: C_NO_INPUT,   target: S_WAIT};
      S_SCALE:       w = '{op: OP_MUL_SCALE, cond: C_NEVER,      target: S_WAIT};
      S_DIV_MS:      w = '{op: OP_DIV_MS,    cond: C_NEVER,      target: S_WAIT};
      S_DIV_MS_WAIT: w = '{op: OP_NONE,      cond: C_DIV_BUSY,   target: S_DIV_MS_WAIT};
      S_TICKS:       w = '{op: OP_MUL_TICKS, cond: C_NEVER,      target: S_WAIT};
      S_ZERO_CHK:    w = '{op: OP_SET_D1,    cond: C_TICKS_ZERO, target: S_FAIL};
      S_DIV_D:       w = '{op: OP_DIV_D,     cond: C_NEVER,      target: S_WAIT};
      S_DIV_D_WAIT:  w = '{op: OP_NONE,      cond: C_DIV_BUSY,   target: S_DIV_D_WAIT};
      S_FIT_CHK:     w = '{op: OP_NONE,      cond: C_FIT,        target: S_FOUND};
      S_NEXT_D:      w = '{op: OP_INC_D,     cond: C_D_NOT_LAST, target: S_DIV_D};
      S_FAIL:        w = '{op: OP_SET_FAIL,  cond: C_ALWAYS,     target: S_EMIT};
      S_FOUND:       w = '{op: OP_SET_FOUND, cond: C_Q_SMALL,    target: S_FAIL};
      S_EMIT:        w = '{op: OP_EMIT,      cond: C_OUT_FULL,   target: S_EMIT};
      S_CLOSE:       w = '{op: OP_NONE,      cond: C_ALWAYS,     target: S_WAIT};
      default:       w = '{op: OP_NONE,      cond: C_ALWAYS,     target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

### rtl/tds_div.sv
// restoring divider, one quotient bit per cycle
// depends on tds_pkg for widths
module tds_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tds_pkg::DATA_W-1:0]    dividend,
  input  logic [tds_pkg::DIV_W-1:0]     divisor,
  output logic                          busy,
  output logic [tds_pkg::DATA_W-1:0]    quotient,
  output logic [tds_pkg::DIV_W-1:0]     remainder
);
  import tds_pkg::*;

  logic [DATA_W-1:0]     acc;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      dvs;
  logic [DIV_STEP_W-1:0] count;
  logic [DIV_W:0]        trial;
  logic [DIV_W+1:0]      diff;
  logic                  fits;

  assign trial = {rem, acc[DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && count == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      count <= DIV_STEP_W'(DATA_W - 1);
    end else if (busy) begin
      acc   <= {acc[DATA_W-2:0], fits};
      rem   <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      count <= count - 1'b1;
    end
  end

  assign quotient  = acc;
  assign remainder = rem;

endmodule

### rtl/timer_divider_search.sv
// timer prescaler and reload search, microcoded sequencer over a shared divider
// depends on tds_pkg, tds_div and timer_divider_search_assert.svh
//
// usage:
//   write clock_hz at byte address 0 and clock_multiplier at 4 over the apb port
//   while the block is idle. a request word (period_ms) is taken when req_valid
//   is high and req_stall low; req_stall is high from acceptance through the
//   close step that follows the move of the result into the output register.
//   one result word (status, divider, reload_value, start_count) follows each
//   request on res_valid/res_stall. the output register holds a finished word
//   while the receiver stalls, and the next request is taken meanwhile.
// sequence:
//   the tick total takes two multiplies and one divide.
//   each candidate divisor costs one pass of the bit-serial
//   divider plus start, check and increment steps of the sequencer.
// reset:
//   synchronous; clears the sequencer, the divider and the output valid, and
//   sets clock_hz to 0 and clock_multiplier to 1.
`include "timer_divider_search_assert.svh"

module timer_divider_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tds_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tds_pkg::DATA_W-1:0]       pwdata,
  output logic [tds_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [tds_pkg::CNT_W-1:0]        period_ms,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             status,
  output logic [tds_pkg::CNT_W-1:0]        divider,
  output logic [tds_pkg::CNT_W-1:0]        reload_value,
  output logic [tds_pkg::CNT_W-1:0]        start_count
);
  import tds_pkg::*;

  logic [DATA_W-1:0]   clock_hz;
  logic [CNT_W-1:0]    clock_multiplier;
  logic                cfg_write;

  step_t               step;
  step_t               step_next;
  ucode_t              uw;
  logic                jump;

  logic [CNT_W-1:0]    interval;
  logic [DATA_W-1:0]   scaled;
  logic [DATA_W-1:0]   ticks;
  logic [CNT_W-1:0]    d;
  logic                find_status;
  logic [CNT_W-1:0]    find_divider;
  logic [CNT_W-1:0]    find_reload;
  logic [CNT_W-1:0]    find_start;

  logic [DATA_W+CNT_W-1:0] prod_scale;
  logic [DATA_W+CNT_W-1:0] prod_ticks;

  logic                div_start;
  logic [DATA_W-1:0]   div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic                div_busy;
  logic [DATA_W-1:0]   div_quot;
  logic [DIV_W-1:0]    div_rem;
  logic                out_full;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz         <= '0;
      clock_multiplier <= CNT_W'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        CFG_IDX_CLOCK_HZ:   clock_hz         <= pwdata;
        CFG_IDX_MULTIPLIER: clock_multiplier <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_CLOCK_HZ:   prdata = clock_hz;
      CFG_IDX_MULTIPLIER: prdata = {{(DATA_W-CNT_W){1'b0}}, clock_multiplier};
      default:            prdata = '0;
    endcase
  end

  // sequencer
  assign uw       = ucode_rom(step);
  assign out_full = res_valid && res_stall;

  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !req_valid;
      C_DIV_BUSY:   jump = div_busy;
      C_TICKS_ZERO: jump = (ticks == '0);
      C_FIT:        jump = (div_rem == '0) && (div_quot < DATA_W'(COUNTER_LIMIT));
      C_D_NOT_LAST: jump = (d != CNT_W'(COUNTER_LIMIT - 1));
      C_Q_SMALL:    jump = (div_quot <= DATA_W'(1));
      C_OUT_FULL:   jump = out_full;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    step_next = jump ? uw.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  assign req_stall = (step != S_WAIT);

  // datapath
  assign prod_scale   = clock_hz * clock_multiplier;
  assign prod_ticks   = div_quot * interval;
  assign div_start    = (uw.op == OP_DIV_MS) || (uw.op == OP_DIV_D);
  assign div_dividend = (uw.op == OP_DIV_D) ? ticks : scaled;
  assign div_divisor  = (uw.op == OP_DIV_D) ? d : DIV_W'(MS_PER_SECOND);

  tds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD_IN: begin
        if (req_valid) begin
          interval <= period_ms;
        end
      end
      OP_MUL_SCALE: scaled <= prod_scale[DATA_W-1:0];
      OP_MUL_TICKS: ticks  <= prod_ticks[DATA_W-1:0];
      OP_SET_D1:    d      <= CNT_W'(1);
      OP_INC_D:     d      <= d + 1'b1;
      OP_SET_FAIL: begin
        find_status  <= 1'b1;
        find_divider <= '0;
        find_reload  <= '0;
        find_start   <= '0;
      end
      OP_SET_FOUND: begin
        // quotient is below the counter limit here, so 16 bits hold it
        find_status  <= 1'b0;
        find_divider <= d;
        find_reload  <= div_quot[CNT_W-1:0] - CNT_W'(1);
        find_start   <= div_quot[CNT_W-1:0] - CNT_W'(2);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (uw.op == OP_EMIT && !out_full) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && !out_full) begin
      status       <= find_status;
      divider      <= find_divider;
      reload_value <= find_reload;
      start_count  <= find_start;
    end
  end

  `TDS_ASSERT_NXT(a_accept_starts, clk, rst, req_valid && !req_stall, step == S_SCALE, "request taken but sequencer did not start")
  `TDS_ASSERT_IMP(a_div_wait, clk, rst, div_busy, step == S_DIV_MS_WAIT || step == S_DIV_D_WAIT, "divider busy outside a wait step")
  `TDS_ASSERT_IMP(a_found_consistent, clk, rst, res_valid && !status, divider != '0 && reload_value == start_count + 16'd1, "success word with inconsistent fields")

endmodule
